FILE: design/pbcc_pkg.sv
// shared types and constants of the pseudo-boolean constraint classifier
// no dependencies; imported by the front, back and top level

package pbcc_pkg;

  // fixed field widths
  localparam int BOUND_BITS    = 48;
  localparam int TERM_BITS     = 16;
  localparam int TALLY_BITS    = 32;
  localparam int VAR_OUT_BITS  = 24;
  localparam int SMAX_OUT_BITS = 47;
  localparam int SMIN_OUT_BITS = 48;
  localparam int NUM_CLASSES   = 5;

  typedef enum logic [1:0] {
    OP_CTERM = 2'd0,
    OP_CEND  = 2'd1,
    OP_OTERM = 2'd2,
    OP_OEND  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OBJ_NONE = 2'd0,
    OBJ_OPEN = 2'd1,
    OBJ_DONE = 2'd2
  } obj_state_t;

  typedef enum logic {
    RK_OBJECTIVE  = 1'b0,
    RK_CONSTRAINT = 1'b1
  } rec_kind_t;

  typedef enum logic [2:0] {
    CLS_CLAUSE  = 3'd0,
    CLS_CARD_GE = 3'd1,
    CLS_CARD_EQ = 3'd2,
    CLS_PB_GE   = 3'd3,
    CLS_PB_EQ   = 3'd4
  } class_t;

  localparam logic REL_GE = 1'b0;
  localparam logic REL_EQ = 1'b1;

  // control part of one closed record queued between front and back
  typedef struct packed {
    rec_kind_t kind;
    logic      eq;
    logic      card;
  } rec_flags_t;

endpackage

FILE: design/pb_constraint_classifier_top.sv
// top level of the pseudo-boolean constraint classifier
// depends on pbcc_pkg, pbcc_front, pbcc_fifo, pbcc_back

// The classifier takes a tokenized pseudo-boolean instance one item per cycle
// (constraint term, constraint end, objective term, objective end) and gives
// one result per constraint end and per end of the first objective; later
// objectives are swallowed without a result. Terms never produce a result.
// The front end keeps the running term statistics (saturating positive and
// negative sums, smallest magnitude, equal-magnitude flag, term count and the
// largest variable index plus one) and on every closing end pushes a snapshot
// into a two-entry queue; the back end classifies it (clause, cardinality or
// general pb, >= or =), updates the tallies and loads the result register.
// out_valid is registered and rises once the record has left the queue. Items
// are taken every cycle; in_ready drops only while the queue holds two unread
// records, which happens when out_ready stays low; with one more record waiting
// in the result register a stalled consumer back-pressures after three ends.

module pb_constraint_classifier_top #(
  parameter int VAR_BITS   = 24,
  parameter int COEFF_BITS = 32,
  parameter int SUM_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic signed [COEFF_BITS-1:0]       in_coefficient,
  input  logic [VAR_BITS-1:0]                in_variable_index,
  input  logic                               in_relation,
  input  logic signed [pbcc_pkg::BOUND_BITS-1:0] in_bound,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_record_kind,
  output logic [2:0]                         out_class_code,
  output logic                               out_is_assignment,
  output logic                               out_is_unsat,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_class_tally,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_assignment_tally,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_constraint_tally,
  output logic [pbcc_pkg::VAR_OUT_BITS-1:0]  out_variable_count,
  output logic                               out_unsat_seen,
  output logic [pbcc_pkg::TERM_BITS-1:0]     out_term_count,
  output logic [pbcc_pkg::SMAX_OUT_BITS-1:0] out_sum_max,
  output logic signed [pbcc_pkg::SMIN_OUT_BITS-1:0] out_sum_min
);
  import pbcc_pkg::*;

  localparam int QDEPTH = 2;
  localparam int FW = $bits(rec_flags_t);
  // queue entry: flags, bound, sums, smallest magnitude, terms, highest variable
  localparam int EW = FW + BOUND_BITS + 2 * SUM_BITS + COEFF_BITS + TERM_BITS + VAR_BITS;

  logic                        accept;
  logic                        push, pop, q_full, q_valid;
  op_t                         op;
  logic [EW-1:0]               q_in, q_out;

  // front side record
  rec_flags_t                  f_flags;
  logic signed [BOUND_BITS-1:0] f_bound;
  logic signed [SUM_BITS-1:0]  f_pos, f_neg;
  logic [COEFF_BITS-1:0]       f_small;
  logic [TERM_BITS-1:0]        f_terms;
  logic [VAR_BITS-1:0]         f_high;

  // back side record
  rec_flags_t                  b_flags;
  logic signed [BOUND_BITS-1:0] b_bound;
  logic signed [SUM_BITS-1:0]  b_pos, b_neg;
  logic [COEFF_BITS-1:0]       b_small;
  logic [TERM_BITS-1:0]        b_terms;
  logic [VAR_BITS-1:0]         b_high;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(in_op);

  pbcc_front #(
    .VAR_BITS  (VAR_BITS),
    .COEFF_BITS(COEFF_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .op            (op),
    .coefficient   (in_coefficient),
    .variable_index(in_variable_index),
    .relation      (in_relation),
    .bound         (in_bound),
    .push          (push),
    .rec_flags     (f_flags),
    .rec_bound     (f_bound),
    .rec_pos       (f_pos),
    .rec_neg       (f_neg),
    .rec_smallest  (f_small),
    .rec_terms     (f_terms),
    .rec_highest   (f_high)
  );

  assign q_in = {f_flags, f_bound, f_pos, f_neg, f_small, f_terms, f_high};

  // decouples classification from term intake
  pbcc_fifo #(
    .WIDTH(EW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .pop_data (q_out)
  );

  assign {b_flags, b_bound, b_pos, b_neg, b_small, b_terms, b_high} = q_out;

  pbcc_back #(
    .VAR_BITS  (VAR_BITS),
    .COEFF_BITS(COEFF_BITS),
    .SUM_BITS  (SUM_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_valid           (q_valid),
    .pop                 (pop),
    .rec_flags           (b_flags),
    .rec_bound           (b_bound),
    .rec_pos             (b_pos),
    .rec_neg             (b_neg),
    .rec_smallest        (b_small),
    .rec_terms           (b_terms),
    .rec_highest         (b_high),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_record_kind     (out_record_kind),
    .out_class_code      (out_class_code),
    .out_is_assignment   (out_is_assignment),
    .out_is_unsat        (out_is_unsat),
    .out_class_tally     (out_class_tally),
    .out_assignment_tally(out_assignment_tally),
    .out_constraint_tally(out_constraint_tally),
    .out_variable_count  (out_variable_count),
    .out_unsat_seen      (out_unsat_seen),
    .out_term_count      (out_term_count),
    .out_sum_max         (out_sum_max),
    .out_sum_min         (out_sum_min)
  );

endmodule

FILE: design/pbcc_front.sv
// front end: accepts items, accumulates term statistics, closes records
// depends on pbcc_pkg

module pbcc_front #(
  parameter int VAR_BITS   = 24,
  parameter int COEFF_BITS = 32,
  parameter int SUM_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  pbcc_pkg::op_t                      op,
  input  logic signed [COEFF_BITS-1:0]       coefficient,
  input  logic [VAR_BITS-1:0]                variable_index,
  input  logic                               relation,
  input  logic signed [pbcc_pkg::BOUND_BITS-1:0] bound,
  output logic                               push,
  output pbcc_pkg::rec_flags_t               rec_flags,
  output logic signed [pbcc_pkg::BOUND_BITS-1:0] rec_bound,
  output logic signed [SUM_BITS-1:0]         rec_pos,
  output logic signed [SUM_BITS-1:0]         rec_neg,
  output logic [COEFF_BITS-1:0]              rec_smallest,
  output logic [pbcc_pkg::TERM_BITS-1:0]     rec_terms,
  output logic [VAR_BITS-1:0]                rec_highest
);
  import pbcc_pkg::*;

  localparam int AW = ((SUM_BITS > COEFF_BITS) ? SUM_BITS : COEFF_BITS) + 1;
  localparam logic signed [SUM_BITS-1:0] SUM_HIGH = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LOW  = {1'b1, {(SUM_BITS-1){1'b0}}};
  localparam logic [COEFF_BITS-1:0] MAG_ONES = '1;
  localparam logic [VAR_BITS-1:0]   VAR_ONES = '1;
  localparam logic [TERM_BITS-1:0]  TERM_ONES = '1;

  logic signed [SUM_BITS-1:0]   pos_r, pos_nxt;
  logic signed [SUM_BITS-1:0]   neg_r, neg_nxt;
  logic [COEFF_BITS-1:0]        small_r, small_nxt;
  logic [COEFF_BITS-1:0]        first_r, first_nxt;
  logic                         meq_r, meq_nxt;
  logic [TERM_BITS-1:0]         terms_r, terms_nxt;
  logic [VAR_BITS-1:0]          high_r, high_nxt;
  obj_state_t                   obj_r, obj_nxt;

  logic                         do_term;
  logic signed [COEFF_BITS:0]   c_ext;
  logic signed [COEFF_BITS:0]   mag_ext;
  logic [COEFF_BITS-1:0]        mag;
  logic signed [AW-1:0]         sum_p;
  logic signed [AW-1:0]         sum_n;
  logic [VAR_BITS-1:0]          v_inc;

  assign c_ext   = (COEFF_BITS+1)'(coefficient);
  assign mag_ext = (c_ext < 0) ? -c_ext : c_ext;
  assign mag     = mag_ext[COEFF_BITS-1:0];
  assign sum_p   = AW'(pos_r) + AW'(coefficient);
  assign sum_n   = AW'(neg_r) + AW'(coefficient);
  assign v_inc   = (variable_index == VAR_ONES) ? VAR_ONES : variable_index + 1'b1;

  always_comb begin
    do_term = 1'b0;
    push    = 1'b0;
    obj_nxt = obj_r;
    if (accept) begin
      case (op)
        OP_CTERM: do_term = 1'b1;
        OP_CEND:  push    = 1'b1;
        OP_OTERM: begin
          if (obj_r != OBJ_DONE) begin
            do_term = 1'b1;
            obj_nxt = OBJ_OPEN;
          end
        end
        OP_OEND: begin
          if (obj_r != OBJ_DONE) begin
            push    = 1'b1;
            obj_nxt = OBJ_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    neg_nxt   = neg_r;
    small_nxt = small_r;
    first_nxt = first_r;
    meq_nxt   = meq_r;
    terms_nxt = terms_r;
    high_nxt  = high_r;
    if (push) begin
      pos_nxt   = '0;
      neg_nxt   = '0;
      small_nxt = MAG_ONES;
      first_nxt = '0;
      meq_nxt   = 1'b0;
      terms_nxt = '0;
    end else if (do_term) begin
      if (coefficient < 0) begin
        neg_nxt = (sum_n < AW'(SUM_LOW)) ? SUM_LOW : sum_n[SUM_BITS-1:0];
      end else begin
        pos_nxt = (sum_p > AW'(SUM_HIGH)) ? SUM_HIGH : sum_p[SUM_BITS-1:0];
      end
      if (mag < small_r) small_nxt = mag;
      if (terms_r == '0) begin
        first_nxt = mag;
        meq_nxt   = 1'b1;
      end else if (mag != first_r) begin
        meq_nxt = 1'b0;
      end
      if (terms_r != TERM_ONES) terms_nxt = terms_r + 1'b1;
      if (v_inc > high_r) high_nxt = v_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      neg_r   <= '0;
      small_r <= MAG_ONES;
      first_r <= '0;
      meq_r   <= 1'b0;
      terms_r <= '0;
      high_r  <= '0;
      obj_r   <= OBJ_NONE;
    end else begin
      pos_r   <= pos_nxt;
      neg_r   <= neg_nxt;
      small_r <= small_nxt;
      first_r <= first_nxt;
      meq_r   <= meq_nxt;
      terms_r <= terms_nxt;
      high_r  <= high_nxt;
      obj_r   <= obj_nxt;
    end
  end

  // record snapshot of the statistics before the clear
  assign rec_flags.kind = (op == OP_CEND) ? RK_CONSTRAINT : RK_OBJECTIVE;
  assign rec_flags.eq   = relation;
  assign rec_flags.card = (terms_r != '0) && meq_r;
  assign rec_bound      = bound;
  assign rec_pos        = pos_r;
  assign rec_neg        = neg_r;
  assign rec_smallest   = small_r;
  assign rec_terms      = terms_r;
  assign rec_highest    = high_r;

  a_clear_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (terms_r == '0) && (small_r == MAG_ONES) && (pos_r == '0) && (neg_r == '0))
    else $error("term statistics not cleared after a record closed");

endmodule

FILE: design/pbcc_fifo.sv
// small register queue between the front and back ends
// no package dependencies

module pbcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == DEPTH_C);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_PTR) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == LAST_PTR) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= DEPTH_C) && !(push && full && !pop))
    else $error("queue overflow");

endmodule

FILE: design/pbcc_back.sv
// back end: classifies closed records, keeps tallies, holds the result register
// depends on pbcc_pkg

module pbcc_back #(
  parameter int VAR_BITS   = 24,
  parameter int COEFF_BITS = 32,
  parameter int SUM_BITS   = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               rec_valid,
  output logic                               pop,
  input  pbcc_pkg::rec_flags_t               rec_flags,
  input  logic signed [pbcc_pkg::BOUND_BITS-1:0] rec_bound,
  input  logic signed [SUM_BITS-1:0]         rec_pos,
  input  logic signed [SUM_BITS-1:0]         rec_neg,
  input  logic [COEFF_BITS-1:0]              rec_smallest,
  input  logic [pbcc_pkg::TERM_BITS-1:0]     rec_terms,
  input  logic [VAR_BITS-1:0]                rec_highest,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_record_kind,
  output logic [2:0]                         out_class_code,
  output logic                               out_is_assignment,
  output logic                               out_is_unsat,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_class_tally,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_assignment_tally,
  output logic [pbcc_pkg::TALLY_BITS-1:0]    out_constraint_tally,
  output logic [pbcc_pkg::VAR_OUT_BITS-1:0]  out_variable_count,
  output logic                               out_unsat_seen,
  output logic [pbcc_pkg::TERM_BITS-1:0]     out_term_count,
  output logic [pbcc_pkg::SMAX_OUT_BITS-1:0] out_sum_max,
  output logic signed [pbcc_pkg::SMIN_OUT_BITS-1:0] out_sum_min
);
  import pbcc_pkg::*;

  localparam int CW = ((SUM_BITS > BOUND_BITS) ? SUM_BITS : BOUND_BITS) + 2;
  localparam int HW = (VAR_BITS > VAR_OUT_BITS) ? VAR_BITS : VAR_OUT_BITS;

  logic [TALLY_BITS-1:0] cat_r [NUM_CLASSES];
  logic [TALLY_BITS-1:0] asg_r, asg_nxt;
  logic [TALLY_BITS-1:0] cons_r, cons_nxt;
  logic                  unsat_r, unsat_nxt;
  logic                  vld_r;

  logic signed [CW-1:0]  mx, mn, sm, b;
  logic                  unsat_c, assign_c, clause_c, is_con;
  class_t                cls;
  logic [TALLY_BITS-1:0] cat_inc;
  logic signed [63:0]    pos64, neg64;
  logic [HW-1:0]         high_ext;

  assign pop    = rec_valid && (!vld_r || out_ready);
  assign is_con = (rec_flags.kind == RK_CONSTRAINT);

  assign mx = CW'(rec_pos);
  assign mn = CW'(rec_neg);
  assign sm = CW'({1'b0, rec_smallest});
  assign b  = CW'(rec_bound);

  always_comb begin
    if (rec_flags.eq == REL_EQ) begin
      unsat_c  = (mn > b) || (mx < b);
      assign_c = (b == mx) || (b == mn);
      clause_c = 1'b0;
    end else begin
      unsat_c  = mx < b;
      assign_c = ((mx - sm) < b) && (mx > b);
      clause_c = (b > mn) && (b <= (mn + sm));
    end
    if (clause_c) cls = CLS_CLAUSE;
    else if (rec_flags.card) cls = (rec_flags.eq == REL_EQ) ? CLS_CARD_EQ : CLS_CARD_GE;
    else cls = (rec_flags.eq == REL_EQ) ? CLS_PB_EQ : CLS_PB_GE;
  end

  assign cat_inc = cat_r[cls] + 1'b1;

  always_comb begin
    asg_nxt   = asg_r;
    cons_nxt  = cons_r;
    unsat_nxt = unsat_r;
    if (pop && is_con) begin
      cons_nxt = cons_r + 1'b1;
      if (assign_c) asg_nxt = asg_r + 1'b1;
      if (unsat_c) unsat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) cat_r[i] <= '0;
      asg_r   <= '0;
      cons_r  <= '0;
      unsat_r <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      if (pop && is_con) cat_r[cls] <= cat_inc;
      asg_r   <= asg_nxt;
      cons_r  <= cons_nxt;
      unsat_r <= unsat_nxt;
      if (pop) vld_r <= 1'b1;
      else if (out_ready) vld_r <= 1'b0;
    end
  end

  assign pos64    = 64'(rec_pos);
  assign neg64    = 64'(rec_neg);
  assign high_ext = HW'(rec_highest);

  // result register, payload without reset
  always_ff @(posedge clk) begin
    if (pop) begin
      out_record_kind      <= rec_flags.kind;
      out_class_code       <= is_con ? cls : CLS_CLAUSE;
      out_is_assignment    <= is_con && assign_c;
      out_is_unsat         <= is_con && unsat_c;
      out_class_tally      <= is_con ? cat_inc : '0;
      out_assignment_tally <= asg_nxt;
      out_constraint_tally <= cons_nxt;
      out_variable_count   <= high_ext[VAR_OUT_BITS-1:0];
      out_unsat_seen       <= unsat_nxt;
      out_term_count       <= rec_terms;
      out_sum_max          <= pos64[SMAX_OUT_BITS-1:0];
      out_sum_min          <= neg64[SMIN_OUT_BITS-1:0];
    end
  end

  assign out_valid = vld_r;

  a_unsat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    unsat_r |=> unsat_r)
    else $error("unsat flag cleared");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_con) |=> (vld_r && out_constraint_tally == cons_r
                         && cons_r == $past(cons_r) + 1'b1))
    else $error("constraint tally out of step with results");

endmodule
